>>> sv/lbs_pkg.sv
// Package for the LED breathing sequencer: register indexes, field widths
// and the packed result type. No dependencies.
`default_nettype none

package lbs_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned FLIPS_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned LED_W    = 2;
  localparam int unsigned NUM_LEDS_MAX = 4;

  localparam logic [2:0] CFG_PWM_PERIOD = 3'd0;
  localparam logic [2:0] CFG_FLIPS_LED0 = 3'd1;
  localparam logic [2:0] CFG_FLIPS_LED1 = 3'd2;
  localparam logic [2:0] CFG_FLIPS_LED2 = 3'd3;
  localparam logic [2:0] CFG_FLIPS_LED3 = 3'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  localparam logic [FLIPS_W-1:0]  FLIPS_RESET  = 8'd1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 9'd511;
  localparam logic [PERIOD_W-1:0] TIMER_MAX    = 16'hFFFF;

  // first field in the highest bits
  typedef struct packed {
    logic                led_advanced;
    logic [PERIOD_W-1:0] duty_ticks;
    logic                led_lit;
    logic [LED_W-1:0]    led_index;
  } result_t;

endpackage

`default_nettype wire

>>> sv/led_breathing_sequencer.sv
// LED breathing sequencer top level: input register, tick update logic and
// result register. Depends on lbs_pkg.
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  in_tdata[0] ramp_enable
//  out_     master     out_tvalid/out_tready out_tdata: led_index, led_lit,
//                                           duty_ticks, led_advanced
//  cfg_     slave      cfg_valid/cfg_ready  cfg_addr register index, cfg_data
//
// One transaction per cycle sustained while out_tready stays high; each tick passes
// through the input register and then the result register.
// The result register and input register together absorb an output stall.
// rst_n is synchronous, active low; it restores the register reset values.
// cfg_ready drops while a tick waits in the input register; write only while idle.
`default_nettype none

module led_breathing_sequencer #(
  parameter int unsigned LED_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] ramp_enable, [7:1] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [1:0] led_index, [2] led_lit,
                                       // [18:3] duty_ticks, [19] led_advanced
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned PW = lbs_pkg::PERIOD_W;
  localparam int unsigned CW = lbs_pkg::COUNT_W;
  localparam int unsigned LW = lbs_pkg::LED_W;
  localparam logic [LW-1:0] LAST_LED = LW'(LED_COUNT - 1);

  logic [PW-1:0] pwm_period_r;
  logic [lbs_pkg::FLIPS_W-1:0] flips_r [lbs_pkg::NUM_LEDS_MAX];

  logic [LW-1:0] current_led_r, current_led_nxt;
  logic [CW-1:0] flip_count_r, flip_count_nxt;
  logic          ramp_up_r, ramp_up_nxt;
  logic          prev_ramp_up_r, prev_ramp_up_nxt;
  logic [PW-1:0] on_time_r, on_time_nxt;
  logic [PW-1:0] off_time_r, off_time_nxt;
  logic          dark_r, dark_nxt;
  logic [PW-1:0] timer_r, timer_nxt;

  logic s1_valid_r;
  logic s1_ramp_r;
  logic out_valid_r;
  lbs_pkg::result_t res_r, res_nxt;

  logic step;
  logic cfg_wr;

  assign step      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || step;
  assign cfg_ready = !s1_valid_r;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r};

  logic [CW-1:0] limit;
  logic          advance;
  logic          dark_a;
  logic [PW-1:0] timer_a;
  logic          wrap_period;
  logic [PW-1:0] on_inc, on_dec, on_ramp;
  logic          up_ramp;

  always_comb begin
    limit   = {flips_r[current_led_r], 1'b0};
    advance = (flip_count_r >= limit);

    if (!dark_r && (timer_r >= on_time_r)) begin
      dark_a  = 1'b1;
      timer_a = '0;
    end else begin
      dark_a  = dark_r;
      timer_a = timer_r;
    end
    wrap_period = dark_a && (timer_a >= off_time_r);

    on_inc = (on_time_r < pwm_period_r) ? on_time_r + 1'b1 : on_time_r;
    on_dec = (on_time_r != '0) ? on_time_r - 1'b1 : on_time_r;
    if (ramp_up_r) begin
      if (on_inc >= pwm_period_r) begin
        on_ramp = pwm_period_r;
        up_ramp = 1'b0;
      end else begin
        on_ramp = on_inc;
        up_ramp = 1'b1;
      end
    end else begin
      on_ramp = on_dec;
      up_ramp = (on_dec == '0);
    end

    current_led_nxt  = current_led_r;
    flip_count_nxt   = flip_count_r;
    ramp_up_nxt      = ramp_up_r;
    prev_ramp_up_nxt = prev_ramp_up_r;
    on_time_nxt      = on_time_r;
    off_time_nxt     = off_time_r;
    dark_nxt         = dark_r;
    timer_nxt        = timer_r;

    if (advance) begin
      flip_count_nxt  = '0;
      current_led_nxt = (current_led_r >= LAST_LED) ? '0 : current_led_r + 1'b1;
    end else begin
      dark_nxt  = dark_a;
      timer_nxt = timer_a;
      if (wrap_period) begin
        dark_nxt  = 1'b0;
        timer_nxt = '0;
        if (s1_ramp_r) begin
          on_time_nxt  = on_ramp;
          ramp_up_nxt  = up_ramp;
          off_time_nxt = pwm_period_r - on_ramp;
        end
      end
      if (prev_ramp_up_r != ramp_up_nxt) begin
        prev_ramp_up_nxt = ramp_up_nxt;
        if (flip_count_r < lbs_pkg::COUNT_MAX) begin
          flip_count_nxt = flip_count_r + 1'b1;
        end
      end
    end
    if (timer_nxt < lbs_pkg::TIMER_MAX) begin
      timer_nxt = timer_nxt + 1'b1;
    end

    res_nxt.led_index    = current_led_nxt;
    res_nxt.led_lit      = !(advance || dark_nxt);
    res_nxt.duty_ticks   = on_time_nxt;
    res_nxt.led_advanced = advance;
  end

  logic [PW-1:0] cfg_on_clamp;
  assign cfg_on_clamp = (on_time_r > cfg_data) ? cfg_data : on_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r   <= lbs_pkg::PERIOD_RESET;
      flips_r[0]     <= lbs_pkg::FLIPS_RESET;
      flips_r[1]     <= lbs_pkg::FLIPS_RESET;
      flips_r[2]     <= lbs_pkg::FLIPS_RESET;
      flips_r[3]     <= lbs_pkg::FLIPS_RESET;
      current_led_r  <= '0;
      flip_count_r   <= '0;
      ramp_up_r      <= 1'b1;
      prev_ramp_up_r <= 1'b1;
      on_time_r      <= '0;
      off_time_r     <= lbs_pkg::PERIOD_RESET;
      dark_r         <= 1'b0;
      timer_r        <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (step) begin
        current_led_r  <= current_led_nxt;
        flip_count_r   <= flip_count_nxt;
        ramp_up_r      <= ramp_up_nxt;
        prev_ramp_up_r <= prev_ramp_up_nxt;
        on_time_r      <= on_time_nxt;
        off_time_r     <= off_time_nxt;
        dark_r         <= dark_nxt;
        timer_r        <= timer_nxt;
      end else if (cfg_wr) begin
        case (cfg_addr)
          lbs_pkg::CFG_PWM_PERIOD: begin
            pwm_period_r <= cfg_data;
            on_time_r    <= cfg_on_clamp;
            off_time_r   <= cfg_data - cfg_on_clamp;
          end
          lbs_pkg::CFG_FLIPS_LED0: flips_r[0] <= cfg_data[lbs_pkg::FLIPS_W-1:0];
          lbs_pkg::CFG_FLIPS_LED1: flips_r[1] <= cfg_data[lbs_pkg::FLIPS_W-1:0];
          lbs_pkg::CFG_FLIPS_LED2: flips_r[2] <= cfg_data[lbs_pkg::FLIPS_W-1:0];
          lbs_pkg::CFG_FLIPS_LED3: flips_r[3] <= cfg_data[lbs_pkg::FLIPS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_ramp_r <= in_tdata[0];
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  a_on_within_period: assert property (@(posedge clk) disable iff (!rst_n)
    on_time_r <= pwm_period_r)
    else $error("on time exceeds period");

  a_on_off_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, on_time_r} + {1'b0, off_time_r}) == {1'b0, pwm_period_r})
    else $error("on and off time do not sum to period");

  a_led_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    current_led_r <= LAST_LED)
    else $error("LED index out of range");

  a_advance_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && advance |=> flip_count_r == '0 && res_r.led_advanced && !res_r.led_lit)
    else $error("advance tick did not clear count or blank LED");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !step)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> tb/led_breathing_sequencer_tb.sv
`timescale 1ns / 100ps
// Testbench for led_breathing_sequencer: a tick-level duty/sequence predictor checks
// every result transaction. Depends on lbs_pkg and the led_breathing_sequencer RTL.

module led_breathing_sequencer_tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_TICKS = 200;

  class breath_scoreboard;
    logic [lbs_pkg::PERIOD_W-1:0] period;
    logic [lbs_pkg::FLIPS_W-1:0]  flips [lbs_pkg::NUM_LEDS_MAX];
    logic [lbs_pkg::LED_W-1:0]    led;
    logic [lbs_pkg::COUNT_W-1:0]  flip_cnt;
    logic [lbs_pkg::PERIOD_W-1:0] on_t;
    logic [lbs_pkg::PERIOD_W-1:0] off_t;
    logic [lbs_pkg::PERIOD_W-1:0] timer;
    bit                           rising;
    bit                           was_rising;
    bit                           dark;
    lbs_pkg::result_t             expected_ticks[$];
    int                           errors;

    function new();
      period = lbs_pkg::PERIOD_RESET;
      foreach (flips[i]) flips[i] = lbs_pkg::FLIPS_RESET;
      led = '0;
      flip_cnt = '0;
      on_t = '0;
      off_t = lbs_pkg::PERIOD_RESET;
      timer = '0;
      rising = 1'b1;
      was_rising = 1'b1;
      dark = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        lbs_pkg::CFG_PWM_PERIOD: begin
          period = val;
          if (on_t > period) on_t = period;
          off_t = period - on_t;
        end
        lbs_pkg::CFG_FLIPS_LED0: flips[0] = val[lbs_pkg::FLIPS_W-1:0];
        lbs_pkg::CFG_FLIPS_LED1: flips[1] = val[lbs_pkg::FLIPS_W-1:0];
        lbs_pkg::CFG_FLIPS_LED2: flips[2] = val[lbs_pkg::FLIPS_W-1:0];
        lbs_pkg::CFG_FLIPS_LED3: flips[3] = val[lbs_pkg::FLIPS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic ramp_en);
      lbs_pkg::result_t r;
      bit adv;
      adv = 1'b0;
      if (flip_cnt >= {flips[led], 1'b0}) begin
        flip_cnt = '0;
        led = (led == lbs_pkg::NUM_LEDS_MAX - 1) ? '0 : led + 1'b1;
        adv = 1'b1;
      end else begin
        if (!dark && timer >= on_t) begin
          dark = 1'b1;
          timer = '0;
        end
        if (dark && timer >= off_t) begin
          dark = 1'b0;
          timer = '0;
          if (ramp_en) begin
            if (rising) begin
              if (on_t < period) on_t++;
              if (on_t >= period) begin
                on_t = period;
                rising = 1'b0;
              end
            end else begin
              if (on_t > 0) on_t--;
              if (on_t == 0) rising = 1'b1;
            end
            off_t = period - on_t;
          end
        end
        if (was_rising != rising) begin
          was_rising = rising;
          if (flip_cnt != lbs_pkg::COUNT_MAX) flip_cnt++;
        end
      end
      if (timer != lbs_pkg::TIMER_MAX) timer++;
      r.led_index = led;
      r.led_lit = !(adv || dark);
      r.duty_ticks = on_t;
      r.led_advanced = adv;
      expected_ticks.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(lbs_pkg::result_t got);
      lbs_pkg::result_t want;
      if (expected_ticks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_ticks.pop_front();
      compare_field("led_index", want.led_index, got.led_index);
      compare_field("led_lit", want.led_lit, got.led_lit);
      compare_field("duty_ticks", want.duty_ticks, got.duty_ticks);
      compare_field("led_advanced", want.led_advanced, got.led_advanced);
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction
  endclass

  typedef struct {
    logic [2:0]  idx;
    logic [15:0] val;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [0] ramp_enable, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [1:0] led_index, [2] led_lit, [18:3] duty_ticks,
                                 // [19] led_advanced
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  bit               calm = 1'b0;
  breath_scoreboard sb = new();
  reg_write_t       reg_q[$];

  led_breathing_sequencer #(.LED_COUNT(lbs_pkg::NUM_LEDS_MAX)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[19:0]);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("led_breathing_sequencer test failed");
    $finish;
  end

  task automatic send_tick(input logic ramp);
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, ramp};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(ramp);
    @(negedge clk);
  endtask

  task automatic flush_regs();
    reg_write_t w;
    while (reg_q.size() != 0) begin
      w = reg_q.pop_front();
      cfg_valid <= 1'b1;
      cfg_addr <= w.idx;
      cfg_data <= w.val;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(w.idx, w.val);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_all_flips(input logic [15:0] val);
    for (int i = 0; i < lbs_pkg::NUM_LEDS_MAX; i++) begin
      reg_q.push_back('{3'(lbs_pkg::CFG_FLIPS_LED0 + i), val});
    end
  endtask

  initial begin
    int random_ticks;
    int phase;
    int n;
    bit coin_ramp;
    int unsigned r;
    random_ticks = 0;
    phase = 0;
    calm = 1'b1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    drain();
    reg_q.push_back('{lbs_pkg::CFG_PWM_PERIOD, 16'd0});
    set_all_flips(16'd1);
    flush_regs();
    repeat (6) send_tick(1'b1);
    drain();
    reg_q.push_back('{lbs_pkg::CFG_FLIPS_LED2, 16'd0});
    reg_q.push_back('{lbs_pkg::CFG_FLIPS_LED3, 16'd0});
    flush_regs();
    repeat (4) send_tick(1'b1);
    drain();
    reg_q.push_back('{lbs_pkg::CFG_PWM_PERIOD, 16'hFFFF});
    set_all_flips(16'd255);
    flush_regs();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    drain();
    reg_q.push_back('{lbs_pkg::CFG_PWM_PERIOD, 16'd2});
    flush_regs();
    repeat (6) send_tick(1'b1);
    drain();
    reg_q.push_back('{lbs_pkg::CFG_PWM_PERIOD, 16'd1});
    reg_q.push_back('{3'd7, 16'hFFFF});
    flush_regs();
    repeat (4) send_tick(1'b1);
    drain();
    calm = 1'b0;

    while (random_ticks < RANDOM_TICKS) begin
      phase++;
      calm = (phase % 9 == 4);
      if ($urandom_range(1) != 0) begin
        r = $urandom_range(99);
        if (r < 40) n = $urandom_range(3);
        else if (r < 80) n = $urandom_range(12, 4);
        else if (r < 95) n = $urandom_range(60, 13);
        else n = $urandom_range(65535, 61);
        reg_q.push_back('{lbs_pkg::CFG_PWM_PERIOD, 16'(n)});
      end
      for (int i = 0; i < lbs_pkg::NUM_LEDS_MAX; i++) begin
        if ($urandom_range(2) != 0) begin
          n = ($urandom_range(99) < 3) ? 255 : $urandom_range(3);
          reg_q.push_back('{3'(lbs_pkg::CFG_FLIPS_LED0 + i), 16'(n)});
        end
      end
      if ($urandom_range(9) == 0) reg_q.push_back('{3'($urandom_range(7, 5)), 16'($urandom)});
      flush_regs();
      coin_ramp = ($urandom_range(4) == 0);
      n = $urandom_range(90, 20);
      repeat (n) begin
        send_tick(coin_ramp ? 1'($urandom_range(1)) : ($urandom_range(99) < 85));
      end
      random_ticks += n;
      drain();
    end

    calm = 1'b0;
    reg_q.push_back('{lbs_pkg::CFG_PWM_PERIOD, 16'd0});
    set_all_flips(16'd255);
    flush_regs();
    repeat (530) send_tick(1'b1);
    drain();

    reg_q.push_back('{lbs_pkg::CFG_PWM_PERIOD, 16'd3});
    set_all_flips(16'd2);
    flush_regs();
    repeat (60) send_tick(1'b1);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("led_breathing_sequencer test passed");
    end else begin
      $display("led_breathing_sequencer test failed");
    end
    $finish;
  end

endmodule

>>> led_breathing_sequencer.f
sv/lbs_pkg.sv
sv/led_breathing_sequencer.sv
tb/led_breathing_sequencer_tb.sv
